[rtl/ownership_failover_table_assert.svh]
// Assertion macros for the ownership failover table
`ifndef OWNERSHIP_FAILOVER_TABLE_ASSERT_SVH
`define OWNERSHIP_FAILOVER_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define OFT_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define OFT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define OFT_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define OFT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

[rtl/oft_pkg.sv]
`default_nettype none
package oft_pkg;
    localparam int DEFAULT_TABLE_DEPTH = 16;

    localparam logic [2:0] ACT_REG_LOCAL = 3'd0;
    localparam logic [2:0] ACT_SET_OWNER = 3'd1;
    localparam logic [2:0] ACT_OFFLINE   = 3'd2;
    localparam logic [2:0] ACT_ONLINE    = 3'd3;
    localparam logic [2:0] ACT_PEER      = 3'd4;
    localparam logic [2:0] ACT_QUERY     = 3'd5;

    localparam logic [2:0] ST_DONE       = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_ZERO_ID    = 3'd2;
    localparam logic [2:0] ST_NOT_ADMIT  = 3'd3;
    localparam logic [2:0] ST_CONFLICT   = 3'd4;
    localparam logic [2:0] ST_UNCHANGED  = 3'd5;
    localparam logic [2:0] ST_NOT_MASTER = 3'd6;

    localparam logic KIND_BCAST = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] io_id;
        logic [31:0] node;
        logic [31:0] home_node;
        logic [31:0] master;
        logic        node_admitted;
        logic        home_admitted;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] out_io_id;
        logic [31:0] out_owner;
        logic [31:0] out_home;
        logic        found;
        logic        is_local;
        logic [2:0]  status;
        logic        last;
    } out_item_t;

    // one table row: key, owner, home
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] owner;
        logic [31:0] home;
    } row_t;
endpackage
`default_nettype wire

[rtl/ownership_failover_table.sv]
// Ownership failover table.
// Input channel in_valid/in_ready carries one request (in_item) per action; output
// channel out_valid/out_ready returns results (out_item): zero or more ownership
// broadcasts (kind 0) followed by exactly one completion (kind 1, last = 1).
// cfg_we/cfg_data writes the local node id at once; write it only while idle.
// A request walks the table through a single registered-read RAM port, one row at a
// time (present address, then compare); each broadcast waits in an emit state until
// it is taken. Register, set owner, peer update and query scan the table once, then
// write the chosen row or report in a last step before completing. Offline scans the
// table once; online walks it twice, handing rows back and then re-broadcasting all.
// Zero id, not master and unused codes complete on the next cycle; a peer update
// that is not admitted completes from the address state. in_ready is high only when
// the sequencer is idle, so one request is in flight at a time.
// Each result sits in an output register; when the receiver stalls the scan holds
// on that row until the result is taken.
// Reset clears the valid bits (flip-flops), the node id and the sequencer; table
// contents are left as they are and are read only behind a valid bit.
`default_nettype none
module ownership_failover_table #(
    parameter int TABLE_DEPTH = oft_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire oft_pkg::in_item_t in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output oft_pkg::out_item_t     out_item,
    input  wire logic              cfg_we,
    input  wire logic [31:0]       cfg_data
);
    import oft_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] LAST_ROW = CW'(TABLE_DEPTH - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADDR  = 3'd1; // present address, wait for read data
    localparam logic [2:0] S_EVAL  = 3'd2; // compare read row
    localparam logic [2:0] S_EMIT  = 3'd3; // wait for broadcast to be taken
    localparam logic [2:0] S_WRITE = 3'd4; // write the chosen row (not for query) and build completion
    localparam logic [2:0] S_DONE  = 3'd5; // completion in output register

    logic [2:0]       state_reg, state_next;
    in_item_t         req_reg, req_next;
    logic [31:0]      self_reg;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic             pass_reg, pass_next;   // online: second (re-broadcast) pass
    logic             hit_reg, hit_next;
    logic [IW-1:0]    hit_idx_reg, hit_idx_next;
    row_t             hit_row_reg, hit_row_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;

    logic             ram_we;
    logic [IW-1:0]    ram_waddr, ram_raddr;
    row_t             ram_wdata, ram_rdata;

    oft_ram #(.WIDTH($bits(row_t)), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [IW-1:0] cur;
    logic          cur_valid;
    logic          have_free;
    logic [IW-1:0] free_idx;

    assign cur       = idx_reg[IW-1:0];
    assign cur_valid = valid_reg[cur];
    assign ram_raddr = cur;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // lowest free slot from the valid flops
    always_comb
    begin
        have_free = 1'b0;
        free_idx  = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                have_free = 1'b1;
                free_idx  = IW'(i);
            end
        end
    end

    function automatic out_item_t done_item(input logic [31:0] id, input logic [2:0] st);
        out_item_t o;
        o = '0;
        o.kind = KIND_DONE;
        o.out_io_id = id;
        o.status = st;
        o.last = 1'b1;
        return o;
    endfunction

    function automatic out_item_t bcast_item(input row_t r);
        out_item_t o;
        o = '0;
        o.kind = KIND_BCAST;
        o.out_io_id = r.key;
        o.out_owner = r.owner;
        o.out_home = r.home;
        return o;
    endfunction

    logic adm_node, adm_home;
    assign adm_node = (req_reg.node == '0) || (req_reg.node == self_reg)
                      || req_reg.node_admitted;
    assign adm_home = (req_reg.home_node == '0) || (req_reg.home_node == self_reg)
                      || req_reg.home_admitted;

    always_comb
    begin
        row_t        r;
        logic        match;
        logic        scan_end;
        out_item_t   q;
        state_next     = state_reg;
        req_next       = req_reg;
        valid_next     = valid_reg;
        idx_next       = idx_reg;
        pass_next      = pass_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_row_next   = hit_row_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur;
        ram_wdata      = ram_rdata;
        r              = ram_rdata;
        match          = 1'b0;
        scan_end       = (idx_reg == LAST_ROW);
        q              = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next  = in_item;
                    idx_next  = '0;
                    pass_next = 1'b0;
                    hit_next  = 1'b0;
                    priority if (in_item.action == ACT_REG_LOCAL && in_item.io_id == '0)
                    begin
                        out_next = done_item(in_item.io_id, ST_ZERO_ID);
                        out_valid_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else if (in_item.action == ACT_OFFLINE && self_reg != in_item.master)
                    begin
                        out_next = done_item(in_item.io_id, ST_NOT_MASTER);
                        out_valid_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else if (in_item.action > ACT_QUERY)
                    begin
                        out_next = done_item(in_item.io_id, ST_DONE);
                        out_valid_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ADDR;
                    end
                end
            end
            S_ADDR:
            begin
                if (req_reg.action == ACT_PEER && !(adm_node && adm_home))
                begin
                    out_next = done_item(req_reg.io_id, ST_NOT_ADMIT);
                    out_valid_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                unique case (req_reg.action)
                    ACT_OFFLINE:
                        match = cur_valid && (r.owner == req_reg.node);
                    ACT_ONLINE:
                        match = pass_reg ? cur_valid
                              : (cur_valid && r.home == req_reg.node && r.owner == self_reg);
                    default:
                        match = cur_valid && !hit_reg && (r.key == req_reg.io_id);
                endcase
                if (req_reg.action == ACT_OFFLINE || req_reg.action == ACT_ONLINE)
                begin
                    if (match)
                    begin
                        // modify in place and broadcast the new row
                        if (req_reg.action == ACT_OFFLINE)
                        begin
                            r.owner = self_reg;
                        end
                        else if (!pass_reg)
                        begin
                            r.owner = req_reg.node;
                        end
                        ram_we = 1'b1;
                        ram_wdata = r;
                        out_next = bcast_item(r);
                        out_valid_next = 1'b1;
                        state_next = S_EMIT;
                    end
                    else if (scan_end)
                    begin
                        if (req_reg.action == ACT_ONLINE && !pass_reg)
                        begin
                            pass_next = 1'b1;
                            idx_next = '0;
                            state_next = S_ADDR;
                        end
                        else
                        begin
                            out_next = done_item(req_reg.io_id, ST_DONE);
                            out_valid_next = 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        state_next = S_ADDR;
                    end
                end
                else
                begin
                    if (match)
                    begin
                        hit_next = 1'b1;
                        hit_idx_next = cur;
                        hit_row_next = r;
                    end
                    if (scan_end)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        state_next = S_ADDR;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_valid_reg && out_ready)
                begin
                    if (scan_end)
                    begin
                        if (req_reg.action == ACT_ONLINE && !pass_reg)
                        begin
                            pass_next = 1'b1;
                            idx_next = '0;
                        end
                        else
                        begin
                            out_next = done_item(req_reg.io_id, ST_DONE);
                            out_valid_next = 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                    if (state_next == S_EMIT)
                    begin
                        state_next = S_ADDR;
                    end
                end
            end
            S_WRITE:
            begin
                ram_waddr = hit_reg ? hit_idx_reg : free_idx;
                ram_wdata.key = req_reg.io_id;
                ram_wdata.owner = self_reg;
                ram_wdata.home = self_reg;
                out_next = done_item(req_reg.io_id, ST_DONE);
                unique case (req_reg.action)
                    ACT_QUERY:
                    begin
                        q = '0;
                        q.kind = KIND_DONE;
                        q.out_io_id = req_reg.io_id;
                        q.last = 1'b1;
                        if (hit_reg)
                        begin
                            q.out_owner = hit_row_reg.owner;
                            q.out_home = hit_row_reg.home;
                            q.found = 1'b1;
                            q.is_local = (self_reg == '0) || (hit_row_reg.owner == self_reg);
                        end
                        else
                        begin
                            q.out_owner = self_reg;
                            q.out_home = self_reg;
                            q.is_local = 1'b1;
                        end
                        out_next = q;
                    end
                    ACT_PEER:
                    begin
                        ram_wdata.owner = req_reg.node;
                        ram_wdata.home = req_reg.home_node;
                        priority if (hit_reg && hit_row_reg.home == self_reg
                                     && req_reg.home_node != self_reg)
                        begin
                            out_next.status = ST_CONFLICT;
                        end
                        else if (hit_reg && hit_row_reg.owner == req_reg.node
                                 && hit_row_reg.home == req_reg.home_node)
                        begin
                            out_next.status = ST_UNCHANGED;
                        end
                        else if (!hit_reg && !have_free)
                        begin
                            out_next.status = ST_FULL;
                        end
                        else
                        begin
                            ram_we = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (req_reg.action == ACT_SET_OWNER)
                        begin
                            ram_wdata.owner = req_reg.node;
                            ram_wdata.home = req_reg.home_node;
                        end
                        if (!hit_reg && !have_free)
                        begin
                            out_next.status = ST_FULL;
                        end
                        else
                        begin
                            ram_we = 1'b1;
                        end
                    end
                endcase
                if (ram_we)
                begin
                    valid_next[ram_waddr] = 1'b1;
                end
                out_valid_next = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_valid_reg && out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            self_reg      <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            pass_reg      <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            pass_reg      <= pass_next;
            hit_reg       <= hit_next;
            if (cfg_we)
            begin
                self_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        hit_idx_reg <= hit_idx_next;
        hit_row_reg <= hit_row_next;
        out_reg     <= out_next;
    end

`include "ownership_failover_table_assert.svh"

    `OFT_ASSERT_IMPL(a_ready_idle, clk, rst_n, !(in_ready && out_valid && out_item.last == 1'b0), "broadcast pending while idle")
    `OFT_ASSERT_NEXT(a_done_idle, clk, rst_n, (state_reg == S_DONE && out_valid && out_ready), (in_ready && !out_valid), "completion not followed by idle")
    `OFT_ASSERT_IMPL(a_done_last, clk, rst_n, (state_reg != S_DONE || !out_valid || out_item.last), "completion state without last")
    `OFT_ASSERT_NEXT(a_accept_busy, clk, rst_n, (in_valid && in_ready), !in_ready, "accepted request left block idle")
endmodule
`default_nettype wire

[rtl/oft_ram.sv]
`default_nettype none
module oft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[tb/sv/ownership_failover_table_test.sv]
`default_nettype none
module ownership_failover_table_test;
    timeunit 1ns;
    timeprecision 1ps;
    import oft_pkg::*;

    localparam int DEPTH = DEFAULT_TABLE_DEPTH;
    // Worst case is far below this; the counter only guards against a hang.
    localparam int CYCLE_LIMIT = 1000000;
    // Online walks the table twice; wait this long before writing the node id.
    localparam int SETTLE_CYCLES = 2 * DEPTH + 12;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;
    logic      cfg_we = 1'b0;
    logic [31:0] cfg_data = '0;

    // Local copy of the table and the node id register.
    logic [31:0] self_id;
    logic        row_valid [DEPTH];
    logic [31:0] row_key   [DEPTH];
    logic [31:0] row_owner [DEPTH];
    logic [31:0] row_home  [DEPTH];

    out_item_t pending_results [$];
    int        errors = 0;
    int        cycles = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_cycles = 0;

    ownership_failover_table uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic out_item_t make_result(logic k, logic [31:0] id, logic [31:0] own,
                                              logic [31:0] hm, logic fnd, logic loc,
                                              logic [2:0] st, logic lst);
        out_item_t r;
        r.kind = k;
        r.out_io_id = id;
        r.out_owner = own;
        r.out_home = hm;
        r.found = fnd;
        r.is_local = loc;
        r.status = st;
        r.last = lst;
        return r;
    endfunction

    function automatic int find_row(logic [31:0] id);
        for (int i = 0; i < DEPTH; i++)
            if (row_valid[i] && row_key[i] == id)
                return i;
        return -1;
    endfunction

    function automatic int free_row();
        for (int i = 0; i < DEPTH; i++)
            if (!row_valid[i])
                return i;
        return -1;
    endfunction

    function automatic bit node_admitted(logic [31:0] nd, logic adm);
        return nd == 0 || nd == self_id || adm;
    endfunction

    function automatic void push_broadcast(int s);
        pending_results.push_back(make_result(KIND_BCAST, row_key[s], row_owner[s],
                                              row_home[s], 1'b0, 1'b0, ST_DONE, 1'b0));
    endfunction

    // Update the table for one action and queue the results it produces.
    function automatic void apply_action(in_item_t r);
        logic [2:0] st;
        int s;
        st = ST_DONE;
        case (r.action)
            ACT_REG_LOCAL, ACT_SET_OWNER:
            begin
                if (r.action == ACT_REG_LOCAL && r.io_id == 0)
                    st = ST_ZERO_ID;
                else
                begin
                    s = find_row(r.io_id);
                    if (s < 0)
                        s = free_row();
                    if (s < 0)
                        st = ST_FULL;
                    else
                    begin
                        row_valid[s] = 1'b1;
                        row_key[s] = r.io_id;
                        row_owner[s] = (r.action == ACT_REG_LOCAL) ? self_id : r.node;
                        row_home[s] = (r.action == ACT_REG_LOCAL) ? self_id : r.home_node;
                    end
                end
            end
            ACT_OFFLINE:
            begin
                if (self_id != r.master)
                    st = ST_NOT_MASTER;
                else
                    for (int i = 0; i < DEPTH; i++)
                        if (row_valid[i] && row_owner[i] == r.node)
                        begin
                            row_owner[i] = self_id;
                            push_broadcast(i);
                        end
            end
            ACT_ONLINE:
            begin
                // hand back first, then re-announce the whole table
                for (int i = 0; i < DEPTH; i++)
                    if (row_valid[i] && row_home[i] == r.node && row_owner[i] == self_id)
                    begin
                        row_owner[i] = r.node;
                        push_broadcast(i);
                    end
                for (int i = 0; i < DEPTH; i++)
                    if (row_valid[i])
                        push_broadcast(i);
            end
            ACT_PEER:
            begin
                s = find_row(r.io_id);
                if (!node_admitted(r.node, r.node_admitted)
                    || !node_admitted(r.home_node, r.home_admitted))
                    st = ST_NOT_ADMIT;
                else if (s >= 0 && row_home[s] == self_id && r.home_node != self_id)
                    st = ST_CONFLICT;
                else if (s >= 0 && row_owner[s] == r.node && row_home[s] == r.home_node)
                    st = ST_UNCHANGED;
                else
                begin
                    if (s < 0)
                        s = free_row();
                    if (s < 0)
                        st = ST_FULL;
                    else
                    begin
                        row_valid[s] = 1'b1;
                        row_key[s] = r.io_id;
                        row_owner[s] = r.node;
                        row_home[s] = r.home_node;
                    end
                end
            end
            ACT_QUERY:
            begin
                s = find_row(r.io_id);
                if (s < 0)
                    pending_results.push_back(make_result(KIND_DONE, r.io_id, self_id,
                                              self_id, 1'b0, 1'b1, ST_DONE, 1'b1));
                else
                    pending_results.push_back(make_result(KIND_DONE, r.io_id, row_owner[s],
                                              row_home[s], 1'b1,
                                              self_id == 0 || row_owner[s] == self_id,
                                              ST_DONE, 1'b1));
                return;
            end
            default: ;
        endcase
        pending_results.push_back(make_result(KIND_DONE, r.io_id, '0, '0, 1'b0, 1'b0,
                                              st, 1'b1));
    endfunction

    // Offer one request, with an optional idle gap in front; hold valid until taken.
    task automatic send_request(in_item_t r);
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_item = r;
        do
            @(posedge clk);
        while (!in_ready);
        apply_action(r);
    endtask

    task automatic send_fields(logic [2:0] act, logic [31:0] id, logic [31:0] nd,
                               logic [31:0] hm, logic [31:0] mst, logic na, logic ha);
        in_item_t r;
        r.action = act;
        r.io_id = id;
        r.node = nd;
        r.home_node = hm;
        r.master = mst;
        r.node_admitted = na;
        r.home_admitted = ha;
        send_request(r);
    endtask

    // Drop valid, drain every outstanding result, then let the sequencer settle.
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_self(logic [31:0] v);
        wait_idle();
        cfg_we = 1'b1;
        cfg_data = v;
        @(negedge clk);
        cfg_we = 1'b0;
        self_id = v;
    endtask

    // Receiver: honor a long hold-off first, otherwise stall at the phase's rate.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready = 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
            out_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result taken against the oldest expected one.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result io_id=%h kind=%0d", out_item.out_io_id, out_item.kind);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_item.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, out_item.kind);
                    errors++;
                end
                if (out_item.out_io_id !== want.out_io_id)
                begin
                    $error("out_io_id: expected %h, got %h", want.out_io_id, out_item.out_io_id);
                    errors++;
                end
                if (out_item.out_owner !== want.out_owner)
                begin
                    $error("out_owner: expected %h, got %h", want.out_owner, out_item.out_owner);
                    errors++;
                end
                if (out_item.out_home !== want.out_home)
                begin
                    $error("out_home: expected %h, got %h", want.out_home, out_item.out_home);
                    errors++;
                end
                if (out_item.found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, out_item.found);
                    errors++;
                end
                if (out_item.is_local !== want.is_local)
                begin
                    $error("is_local: expected %0d, got %0d", want.is_local, out_item.is_local);
                    errors++;
                end
                if (out_item.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, out_item.status);
                    errors++;
                end
                if (out_item.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, out_item.last);
                    errors++;
                end
            end
        end
    end

    // Clustering off: everything is local, zero id refused, unused codes complete.
    task automatic test_cluster_inactive();
        send_fields(ACT_REG_LOCAL, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        send_fields(ACT_REG_LOCAL, 32'h5, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        send_fields(ACT_QUERY, 32'h5, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        send_fields(ACT_QUERY, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        send_fields(3'd6, 32'h5, 32'h1, 32'h2, 32'h3, 1'b1, 1'b1);
        send_fields(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    1'b1, 1'b1);
    endtask

    // Every action, and every refusal path but the zero id, with a local node id set.
    task automatic test_actions_directed();
        write_self(32'h1);
        send_fields(ACT_SET_OWNER, 32'h0, 32'h2, 32'h2, 32'h0, 1'b0, 1'b0);
        send_fields(ACT_REG_LOCAL, 32'h10, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        send_fields(ACT_SET_OWNER, 32'h11, 32'h2, 32'h1, 32'h0, 1'b0, 1'b0);
        send_fields(ACT_OFFLINE, 32'h0, 32'h2, 32'h0, 32'h3, 1'b0, 1'b0);
        send_fields(ACT_OFFLINE, 32'h0, 32'h2, 32'h0, 32'h1, 1'b0, 1'b0);
        send_fields(ACT_PEER, 32'h12, 32'h3, 32'h3, 32'h0, 1'b0, 1'b1);
        send_fields(ACT_PEER, 32'h12, 32'h3, 32'h3, 32'h0, 1'b1, 1'b0);
        send_fields(ACT_PEER, 32'h10, 32'h3, 32'h3, 32'h0, 1'b1, 1'b1);
        send_fields(ACT_PEER, 32'h12, 32'h3, 32'h3, 32'h0, 1'b1, 1'b1);
        send_fields(ACT_PEER, 32'h12, 32'h3, 32'h3, 32'h0, 1'b1, 1'b1);
        send_fields(ACT_PEER, 32'h10, 32'h0, 32'h1, 32'h0, 1'b0, 1'b0);
        send_fields(ACT_ONLINE, 32'h0, 32'h3, 32'h0, 32'h0, 1'b0, 1'b0);
        send_fields(ACT_QUERY, 32'h12, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        send_fields(ACT_QUERY, 32'h10, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        // fill the table with registers, then try set owner and peer update on the full table
        for (int i = 0; i < DEPTH; i++)
            send_fields(ACT_REG_LOCAL, 32'h100 + i, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        send_fields(ACT_SET_OWNER, 32'hFFFF_FFFF, 32'h2, 32'h2, 32'h0, 1'b0, 1'b0);
        send_fields(ACT_PEER, 32'hFFFF_FFFF, 32'h2, 32'h2, 32'h0, 1'b1, 1'b1);
        send_fields(ACT_ONLINE, 32'h0, 32'h1, 32'h0, 32'h0, 1'b0, 1'b0);
    endtask

    function automatic logic [31:0] pick_node();
        case ($urandom_range(6))
            0: return 32'h0;
            1, 2: return self_id;
            3, 4: return $urandom_range(1, 3);
            5: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Table is full by now, so half the ids are taken from stored rows and the rest are random or 0 to 3.
    task automatic run_random(int count);
        in_item_t r;
        int s;
        for (int n = 0; n < count; n++)
        begin
            r.action = $urandom_range(99) < 4 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(5));
            s = $urandom_range(DEPTH - 1);
            case ($urandom_range(3))
                0: r.io_id = $urandom;
                1: r.io_id = $urandom_range(0, 3);
                default: r.io_id = row_valid[s] ? row_key[s] : 32'h0;
            endcase
            r.node = pick_node();
            r.home_node = pick_node();
            r.master = $urandom_range(1) ? self_id : pick_node();
            r.node_admitted = $urandom_range(1);
            r.home_admitted = $urandom_range(1);
            send_request(r);
        end
    endtask

    task automatic test_random_idle_phases();
        write_self(32'h2);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_random(40);
        write_self(32'hFFFF_FFFF);
        send_idle_pct = 65;
        run_random(40);
        write_self(32'h3);
        send_idle_pct = 0;
        recv_stall_pct = 65;
        run_random(40);
        write_self(32'h0);
        send_idle_pct = 32;
        recv_stall_pct = 32;
        run_random(40);
    endtask

    // Hold the receiver off while online requests keep coming, so the block backs up.
    task automatic test_output_backpressure();
        write_self(32'h1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 400;
        repeat (4)
            send_fields(ACT_ONLINE, 32'h0, 32'($urandom_range(1, 3)), 32'h0, 32'h0,
                        1'b0, 1'b0);
        send_fields(ACT_OFFLINE, 32'h0, 32'h3, 32'h0, 32'h1, 1'b0, 1'b0);
    endtask

    initial
    begin
        self_id = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            row_valid[i] = 1'b0;
            row_key[i] = '0;
            row_owner[i] = '0;
            row_home[i] = '0;
        end
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_cluster_inactive();
        test_actions_directed();
        test_random_idle_phases();
        test_output_backpressure();

        wait_idle();
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            errors++;
        end
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
